// ===== rtl/core/keyed_list_insert_remove_compact_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_list_insert_remove_compact_defines
// Assertion macros used by the top module of the keyed list block.
// ----------------------------------------------------------------------------
`ifndef KEYED_LIST_INSERT_REMOVE_COMPACT_DEFINES_SVH
`define KEYED_LIST_INSERT_REMOVE_COMPACT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define KLIRC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define KLIRC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/klirc_pkg.sv =====
// ----------------------------------------------------------------------------
// klirc_pkg
// Types and codes shared by the keyed list with insert and compacting remove.
// ----------------------------------------------------------------------------
package klirc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 56;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] count_after;
    logic [COUNT_OUT_W-1:0] free_slots;
  } result_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert_go;
    logic remove_go;
  } cell_ctl_t;

endpackage

// ===== rtl/core/klirc_cell.sv =====
// ----------------------------------------------------------------------------
// klirc_cell
// One slot of the list: holds a key, compares it and shifts from its neighbor.
// ----------------------------------------------------------------------------
module klirc_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                      clk,
  input  klirc_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]          count,
  input  logic [klirc_pkg::KEY_W-1:0] key_in,
  input  logic [klirc_pkg::KEY_W-1:0] upper_key,
  input  logic                      found_in,
  output logic                      found_out,
  output logic [klirc_pkg::KEY_W-1:0] stored
);

  logic occupied;
  logic match;
  logic is_tail;

  assign occupied  = count > CNT_W'(INDEX);
  assign is_tail   = count == CNT_W'(INDEX);
  assign match     = occupied && (stored == key_in);
  // Once a match is seen at or below this slot, on a remove every slot from here up
  // takes the key of its upper neighbor.
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    if (ctl.remove_go && found_out) begin
      stored <= upper_key;
    end else if (ctl.insert_go && is_tail) begin
      stored <= key_in;
    end
  end

endmodule

// ===== rtl/core/keyed_list_insert_remove_compact.sv =====
// ----------------------------------------------------------------------------
// keyed_list_insert_remove_compact
// Bounded list of 56-bit keys in arrival order with keyed, compacting remove.
// ----------------------------------------------------------------------------
// An item is taken in at every rising edge where start is high; busy never
// rises, so a new item may follow in every cycle. Each item gives exactly one
// result, shown on the result port with done high during the cycle after the
// transfer. The whole search, delete and shift happen in the transfer cycle
// through a row of CAPACITY cells, each comparing its key in parallel and
// passing a found flag up the row; that flag ripple sets the clock limit.
// The receiver cannot stall, so results must be captured as they appear.
module keyed_list_insert_remove_compact #(
  parameter int CAPACITY = klirc_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  klirc_pkg::cmd_t    request,
  output logic               done,
  output klirc_pkg::result_t response
);

  `include "keyed_list_insert_remove_compact_defines.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [klirc_pkg::STATUS_W-1:0] status_next;
  klirc_pkg::cell_ctl_t          ctl;
  logic                          full;
  logic                          empty;
  logic [31:0]                   count_ext;
  logic [31:0]                   free_ext;
  logic [CAPACITY:0]             found;
  logic [klirc_pkg::KEY_W-1:0]   keys [CAPACITY];

  assign busy     = 1'b0;
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;
  assign found[0] = 1'b0;

  assign ctl.insert_go = start && (request.operation == klirc_pkg::OP_INSERT) && !full;
  assign ctl.remove_go = start && (request.operation == klirc_pkg::OP_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [klirc_pkg::KEY_W-1:0] upper;
    if (i == CAPACITY - 1) begin : g_last
      assign upper = keys[i];
    end else begin : g_mid
      assign upper = keys[i+1];
    end
    klirc_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .key_in    (request.key),
      .upper_key (upper),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .stored    (keys[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = klirc_pkg::ST_INSERTED;
    if (request.operation == klirc_pkg::OP_INSERT) begin
      if (full) begin
        status_next = klirc_pkg::ST_FULL;
      end else begin
        status_next = klirc_pkg::ST_INSERTED;
        count_next  = count + CNT_W'(1);
      end
    end else if (empty) begin
      status_next = klirc_pkg::ST_EMPTY;
    end else if (found[CAPACITY]) begin
      status_next = klirc_pkg::ST_REMOVED;
      count_next  = count - CNT_W'(1);
    end else begin
      status_next = klirc_pkg::ST_NOTFOUND;
    end
  end

  assign count_ext = 32'(count_next);
  assign free_ext  = 32'(CAPACITY) - count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      response.status      <= status_next;
      response.count_after <= count_ext[klirc_pkg::COUNT_OUT_W-1:0];
      response.free_slots  <= free_ext[klirc_pkg::COUNT_OUT_W-1:0];
    end
  end

  `KLIRC_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `KLIRC_ASSERT_NEXT(a_one_result, start, done, "transfer without a result")
  `KLIRC_ASSERT_NEXT(a_remove_shrinks, ctl.remove_go && found[CAPACITY],
                     count == $past(count) - CNT_W'(1), "remove hit did not shrink list")
  `KLIRC_ASSERT_NEXT(a_full_holds,
                     start && (request.operation == klirc_pkg::OP_INSERT) && full,
                     count == $past(count) && response.status == klirc_pkg::ST_FULL,
                     "insert into full list changed it")

endmodule
